// ===== rtl/core/wcs_pkg.sv =====
// shared types, constants and codes for the wifi channel set
`timescale 1ns / 1ps

package wcs_pkg;

   localparam int FREQ_W   = 16;
   localparam int CHAN_W   = 8;
   localparam int OFFSET_W = 10;
   localparam int PROD_W   = OFFSET_W + CHAN_W;
   localparam int LOW_CHANNELS = 14;
   localparam int LOW_IDX_W    = 4;

   localparam int HIGH_BAND_CHANNELS_DEFAULT = 200;

   // frequency plan in MHz
   localparam logic [FREQ_W-1:0] FREQ_CH14       = 16'd2484;
   localparam logic [FREQ_W-1:0] FREQ_LOW_FIRST  = 16'd2412;
   localparam logic [FREQ_W-1:0] FREQ_LOW_LAST   = 16'd2472;
   localparam logic [FREQ_W-1:0] FREQ_LOW_BASE   = 16'd2407;
   localparam logic [FREQ_W-1:0] FREQ_HI5_FIRST  = 16'd5005;
   localparam logic [FREQ_W-1:0] FREQ_HI5_END    = 16'd5900;
   localparam logic [FREQ_W-1:0] FREQ_HI5_BASE   = 16'd5000;
   localparam logic [FREQ_W-1:0] FREQ_HI4_FIRST  = 16'd4905;
   localparam logic [FREQ_W-1:0] FREQ_HI4_BASE   = 16'd4000;

   localparam logic [CHAN_W-1:0] CHANNEL_14 = 8'd14;

   // x / 5 == (x * 205) >> 10 for any 10-bit x
   localparam int RECIP_5 = 205;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   typedef enum logic [0:0] {
      KIND_ADD  = 1'b0,
      KIND_TEST = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              band;
      logic [CHAN_W-1:0] channel;
   } item_type;

   typedef struct packed {
      logic              hit;
      logic [CHAN_W-1:0] channel;
      logic              band;
   } rsp_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_status_type;

endpackage

// ===== rtl/core/wcs_queue.sv =====
// small first-in first-out queue of flat words
`timescale 1ns / 1ps

module wcs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = pop  ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + PTR_W'(1) : tail_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[head_ff];
   assign count    = count_ff;

endmodule

// ===== rtl/core/wcs_front.sv =====
// front end: maps a frequency to band and channel over two stages
`timescale 1ns / 1ps

module wcs_front
   import wcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  kind_type          in_kind,
   input  logic [FREQ_W-1:0] in_freq,
   output logic              out_valid,
   output item_type          out_item,
   output front_status_type  status
);

   // stage 1: range checks and offset from band base
   logic                s1_valid_ff;
   kind_type            s1_kind_ff, s1_kind_in;
   logic                s1_ok_ff, s1_ok_in;
   logic                s1_ch14_ff, s1_ch14_in;
   logic                s1_band_ff, s1_band_in;
   logic [OFFSET_W-1:0] s1_offset_ff, s1_offset_in;

   logic              in_low, in_hi5, in_hi4;
   logic [FREQ_W-1:0] base;
   logic [FREQ_W-1:0] diff;

   always_comb begin
      in_low = (in_freq >= FREQ_LOW_FIRST) && (in_freq <= FREQ_LOW_LAST);
      in_hi5 = (in_freq >= FREQ_HI5_FIRST) && (in_freq <  FREQ_HI5_END);
      in_hi4 = (in_freq >= FREQ_HI4_FIRST) && (in_freq <  FREQ_HI5_BASE);
      if (in_hi5) begin
         base = FREQ_HI5_BASE;
      end else if (in_hi4) begin
         base = FREQ_HI4_BASE;
      end else begin
         base = FREQ_LOW_BASE;
      end
      diff         = in_freq - base;
      s1_kind_in   = in_kind;
      s1_ok_in     = in_low || in_hi5 || in_hi4;
      s1_ch14_in   = (in_freq == FREQ_CH14);
      s1_band_in   = in_hi5 || in_hi4;
      s1_offset_in = diff[OFFSET_W-1:0];
   end

   // stage 2: divide by five through the reciprocal, exact when the fraction is small
   logic         s2_valid_ff;
   item_type     s2_item_ff, s2_item_in;
   logic [PROD_W-1:0] prod;
   logic [CHAN_W-1:0] quot;
   logic              exact;
   logic              good;

   always_comb begin
      prod  = PROD_W'(s1_offset_ff) * PROD_W'(RECIP_5);
      quot  = prod[PROD_W-1:OFFSET_W];
      exact = prod[OFFSET_W-1:0] < OFFSET_W'(RECIP_5);
      good  = s1_ok_ff && exact;
      s2_item_in.kind = s1_kind_ff;
      if (s1_ch14_ff) begin
         s2_item_in.channel = CHANNEL_14;
         s2_item_in.band    = 1'b0;
      end else if (good) begin
         s2_item_in.channel = quot;
         s2_item_in.band    = s1_band_ff;
      end else begin
         s2_item_in.channel = '0;
         s2_item_in.band    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_ok_ff     <= s1_ok_in;
      s1_ch14_ff   <= s1_ch14_in;
      s1_band_ff   <= s1_band_in;
      s1_offset_ff <= s1_offset_in;
      s2_item_ff   <= s2_item_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;
   assign status    = '{s1_valid: s1_valid_ff, s2_valid: s2_valid_ff};

endmodule

// ===== rtl/core/wcs_back.sv =====
// back end: holds the channel set and runs add and test against it
`timescale 1ns / 1ps

module wcs_back
   import wcs_pkg::*;
#(
   parameter int HIGH_BAND_CHANNELS = HIGH_BAND_CHANNELS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   input  logic     result_room,
   output logic     fire,
   output rsp_type  result
);

   localparam int HI_IDX_W = $clog2(HIGH_BAND_CHANNELS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type               state_ff, state_in;
   logic [HI_IDX_W-1:0]     clear_idx_ff, clear_idx_in;
   logic [LOW_CHANNELS-1:0] low_mask_ff, low_mask_in;

   // high band store, one bit per channel, read data registered
   logic                hi_mem [HIGH_BAND_CHANNELS];
   logic                hi_rd_ff;
   logic                hi_rd_en;
   logic                hi_wr_en;
   logic [HI_IDX_W-1:0] hi_wr_idx;
   logic                hi_wr_bit;

   logic [CHAN_W-1:0]    ch_m1;
   logic [LOW_IDX_W-1:0] low_idx;
   logic [HI_IDX_W-1:0]  hi_idx;
   logic                 nonzero;
   logic                 hi_range;
   logic                 is_add;
   logic                 is_low;
   logic                 is_high;

   always_comb begin
      ch_m1    = item.channel - CHAN_W'(1);
      low_idx  = ch_m1[LOW_IDX_W-1:0];
      hi_idx   = ch_m1[HI_IDX_W-1:0];
      nonzero  = (item.channel != '0);
      hi_range = {1'b0, item.channel} <= (CHAN_W+1)'(HIGH_BAND_CHANNELS);
      is_add   = (item.kind == KIND_ADD);
      is_low   = nonzero && !item.band;
      is_high  = nonzero && item.band && hi_range;

      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      low_mask_in  = low_mask_ff;
      fire         = 1'b0;
      hi_rd_en     = 1'b0;
      hi_wr_en     = 1'b0;
      hi_wr_idx    = hi_idx;
      hi_wr_bit    = 1'b1;

      result.channel = item.channel;
      result.band    = item.band;
      result.hit     = 1'b0;
      if (is_low) begin
         result.hit = is_add ? 1'b1 : low_mask_ff[low_idx];
      end else if (is_high) begin
         result.hit = is_add ? 1'b1 : hi_rd_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            // sweep the high band store to zero, one entry per cycle
            hi_wr_en     = 1'b1;
            hi_wr_idx    = clear_idx_ff;
            hi_wr_bit    = 1'b0;
            clear_idx_in = clear_idx_ff + HI_IDX_W'(1);
            if (clear_idx_ff == HI_IDX_W'(HIGH_BAND_CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               hi_rd_en = is_high;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // head word stays put until it fires
            if (result_room) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
               if (is_add && is_low) begin
                  low_mask_in[low_idx] = 1'b1;
               end
               if (is_add && is_high) begin
                  hi_wr_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         low_mask_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         low_mask_ff  <= low_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hi_wr_en) begin
         hi_mem[hi_wr_idx] <= hi_wr_bit;
      end
      if (hi_rd_en) begin
         hi_rd_ff <= hi_mem[hi_idx];
      end
   end

endmodule

// ===== rtl/core/wifi_channel_set.sv =====
// top level of the wifi channel set: front mapper, mid queue, set engine, result queue
`timescale 1ns / 1ps
//
//   channel   ports                                   direction   word
//   request   req_push req_full req_kind req_freq     in          kind, freq in MHz
//   response  rsp_pop rsp_empty rsp_hit rsp_channel   out         hit, channel, band
//             rsp_band
//
// the mapper takes one word per cycle while mid queue credits last
// the set engine takes one word at a time: read the bit, then answer and write once the result queue has room
// after reset the engine clears the high band store one entry per cycle,
// all HIGH_BAND_CHANNELS entries (200 by default), and takes no word until done
// full rises when the words in the mid queue and in the mapper claim every mid queue slot,
// so a stalled response side backs up into the mid queue, then into full

module wifi_channel_set
   import wcs_pkg::*;
#(
   parameter int HIGH_BAND_CHANNELS = HIGH_BAND_CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_kind,
   input  logic [FREQ_W-1:0] req_freq,
   // response side
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_hit,
   output logic [CHAN_W-1:0] rsp_channel,
   output logic              rsp_band
);

   localparam int MID_CNT_W = $clog2(MID_DEPTH+1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);
   localparam int ITEM_W    = $bits(item_type);
   localparam int RSP_W     = $bits(rsp_type);

   // front end and its in-flight words
   logic             accept;
   logic             front_valid;
   item_type         front_item;
   front_status_type front_status;

   // mid queue between mapper and set engine
   logic [ITEM_W-1:0]    mid_data;
   logic [MID_CNT_W-1:0] mid_count;
   logic [MID_CNT_W:0]   mid_claimed;
   item_type             mid_head;

   // set engine and result queue
   logic                 back_fire;
   rsp_type              back_result;
   logic                 out_pop;
   logic [RSP_W-1:0]     out_data;
   logic [OUT_CNT_W-1:0] out_count;
   rsp_type              out_head;
   logic                 out_room;

   // credit check: every word in the mapper already owns a mid queue slot
   assign mid_claimed = (MID_CNT_W+1)'(mid_count)
                      + (MID_CNT_W+1)'(front_status.s1_valid)
                      + (MID_CNT_W+1)'(front_status.s2_valid);
   assign req_full    = mid_claimed >= (MID_CNT_W+1)'(MID_DEPTH);
   assign accept      = req_push && !req_full;

   wcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_kind   (kind_type'(req_kind)),
      .in_freq   (req_freq),
      .out_valid (front_valid),
      .out_item  (front_item),
      .status    (front_status)
   );

   wcs_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .pop       (back_fire),
      .pop_data  (mid_data),
      .count     (mid_count)
   );

   assign mid_head = item_type'(mid_data);

   // the engine may run when the result queue has a free slot or one leaves now
   assign out_pop  = rsp_pop && !rsp_empty;
   assign out_room = (out_count < OUT_CNT_W'(OUT_DEPTH)) || out_pop;

   wcs_back #(
      .HIGH_BAND_CHANNELS (HIGH_BAND_CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (mid_count != '0),
      .item        (mid_head),
      .result_room (out_room),
      .fire        (back_fire),
      .result      (back_result)
   );

   wcs_queue #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_fire),
      .push_data (back_result),
      .pop       (out_pop),
      .pop_data  (out_data),
      .count     (out_count)
   );

   assign out_head    = rsp_type'(out_data);
   assign rsp_empty   = (out_count == '0);
   assign rsp_hit     = out_head.hit;
   assign rsp_channel = out_head.channel;
   assign rsp_band    = out_head.band;

`ifndef SYNTHESIS
   // credits never hand out more mid queue slots than exist
   a_mid_credit : assert property (@(posedge clock) disable iff (reset)
      mid_claimed <= (MID_CNT_W+1)'(MID_DEPTH))
      else $error("mid queue over-committed");

   // result queue never overfills
   a_out_bound : assert property (@(posedge clock) disable iff (reset)
      out_count <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   // an unmapped frequency gives neither a hit nor the high band
   a_zero_channel : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_channel == '0) |-> (!rsp_hit && !rsp_band))
      else $error("channel zero with hit or band set");

   // an accepted word passes the stage 1 and stage 2 registers and is pushed into the mid queue
   a_front_delay : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 front_valid)
      else $error("mapper lost a word");
`endif

endmodule

// ===== tb/tb_wifi_channel_set.sv =====
// testbench for wifi_channel_set: directed and random add/test words checked against a local set model
`timescale 1ns / 1ps

module tb_wifi_channel_set;
   import wcs_pkg::*;

   // grid step of both band plans in MHz
   localparam int GRID_MHZ = 5;
   // slack for the tail after the last owed response has been popped
   localparam int DRAIN_TAIL = 12;
   // worst case is about 1600 words, each with a send gap, a pop stall and the latency
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP = 18;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_kind;
   logic [FREQ_W-1:0] req_freq;
   logic              rsp_empty;
   logic              rsp_pop;
   logic              rsp_hit;
   logic [CHAN_W-1:0] rsp_channel;
   logic              rsp_band;

   // local copy of the channel set, updated as words are accepted
   logic [LOW_CHANNELS-1:0]             low_set;
   logic [HIGH_BAND_CHANNELS_DEFAULT:1] high_set;

   // responses owed by the block, oldest first
   rsp_type owed_rsp[$];
   rsp_type oldest;

   int errors;
   int cycles;
   // when set, that side runs with no idle cycles
   bit send_quiet;
   bit pop_quiet;

   wifi_channel_set dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_freq    (req_freq),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_hit     (rsp_hit),
      .rsp_channel (rsp_channel),
      .rsp_band    (rsp_band)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit, reached only if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // idle cycles before the next word on one side
   function automatic int draw_gap(input bit quiet);
      if (quiet)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // frequency plan: 2.4 GHz grid, channel 14, the 4.9 GHz and 5 GHz ranges, else channel 0
   function automatic void map_freq(input logic [FREQ_W-1:0] freq,
                                    output logic [CHAN_W-1:0] chan,
                                    output logic band);
      int mhz;
      mhz  = freq;
      chan = '0;
      band = 1'b0;
      if (freq == FREQ_CH14) begin
         chan = CHANNEL_14;
      end else if (freq >= FREQ_LOW_FIRST && freq <= FREQ_LOW_LAST) begin
         if ((mhz - int'(FREQ_LOW_BASE)) % GRID_MHZ == 0)
            chan = CHAN_W'((mhz - int'(FREQ_LOW_BASE)) / GRID_MHZ);
      end else if (freq >= FREQ_HI5_FIRST && freq < FREQ_HI5_END) begin
         if (mhz % GRID_MHZ == 0) begin
            chan = CHAN_W'((mhz - int'(FREQ_HI5_BASE)) / GRID_MHZ);
            band = 1'b1;
         end
      end else if (freq >= FREQ_HI4_FIRST && freq < FREQ_HI5_BASE) begin
         if (mhz % GRID_MHZ == 0) begin
            chan = CHAN_W'((mhz - int'(FREQ_HI4_BASE)) / GRID_MHZ);
            band = 1'b1;
         end
      end
   endfunction

   // apply one accepted word to the local set and return the response it owes
   function automatic rsp_type update_set(input kind_type kind, input logic [FREQ_W-1:0] freq);
      rsp_type r;
      map_freq(freq, r.channel, r.band);
      r.hit = 1'b0;
      if (r.channel != 0) begin
         if (!r.band) begin
            if (kind == KIND_ADD) begin
               low_set[r.channel-1] = 1'b1;
               r.hit = 1'b1;
            end else begin
               r.hit = low_set[r.channel-1];
            end
         end else if (r.channel <= HIGH_BAND_CHANNELS_DEFAULT) begin
            if (kind == KIND_ADD) begin
               high_set[r.channel] = 1'b1;
               r.hit = 1'b1;
            end else begin
               r.hit = high_set[r.channel];
            end
         end
      end
      return r;
   endfunction

   // mostly on-grid channels from both bands, some near-grid and band edges, some raw noise
   function automatic logic [FREQ_W-1:0] pick_freq();
      int r;
      int ch;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         ch = $urandom_range(1, LOW_CHANNELS);
         if (ch == LOW_CHANNELS)
            return FREQ_CH14;
         return FREQ_W'(int'(FREQ_LOW_BASE) + GRID_MHZ * ch);
      end else if (r < 70) begin
         if ($urandom_range(0, 3) == 0)
            return FREQ_W'(int'(FREQ_HI4_FIRST) + GRID_MHZ * $urandom_range(0, 18));
         return FREQ_W'(int'(FREQ_HI5_FIRST) + GRID_MHZ * $urandom_range(0, 178));
      end else if (r < 85) begin
         case ($urandom_range(0, 2))
            0: return FREQ_W'($urandom_range(2400, 2490));
            1: return FREQ_W'($urandom_range(4895, 5010));
            default: return FREQ_W'($urandom_range(5890, 5910));
         endcase
      end
      return FREQ_W'($urandom_range(0, 65535));
   endfunction

   // drive one word at the falling edge and hold it until the block takes it
   task automatic send_word(input kind_type kind, input logic [FREQ_W-1:0] freq);
      int gap;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_kind <= kind;
      req_freq <= freq;
      do @(posedge clock); while (req_full);
      owed_rsp.push_back(update_set(kind, freq));
   endtask

   // stop sending and wait until every owed response has been popped
   task automatic wait_for_drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
   endtask

   // pop side: random stall per word, or none in quiet stretches
   initial begin
      int gap;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = draw_gap(pop_quiet);
         if (gap > 0) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // compare each popped word with the oldest owed response
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (owed_rsp.size() == 0) begin
            $error("unexpected word: hit %0d channel %0d band %0d",
                   rsp_hit, rsp_channel, rsp_band);
            errors++;
         end else begin
            oldest = owed_rsp.pop_front();
            if (rsp_hit !== oldest.hit) begin
               $error("hit: expected %0d, got %0d", oldest.hit, rsp_hit);
               errors++;
            end
            if (rsp_channel !== oldest.channel) begin
               $error("channel: expected %0d, got %0d", oldest.channel, rsp_channel);
               errors++;
            end
            if (rsp_band !== oldest.band) begin
               $error("band: expected %0d, got %0d", oldest.band, rsp_band);
               errors++;
            end
         end
      end
   end

   // band edges, both kinds, invalid frequencies and repeated adds
   task automatic test_directed();
      send_word(KIND_TEST, 16'd2412);   // miss on an empty set
      send_word(KIND_ADD,  16'd2412);   // channel 1
      send_word(KIND_TEST, 16'd2412);
      send_word(KIND_TEST, 16'd5005);   // channel 1 of the other band still absent
      send_word(KIND_ADD,  16'd2472);   // channel 13
      send_word(KIND_ADD,  16'd2484);   // channel 14
      send_word(KIND_TEST, 16'd2484);
      send_word(KIND_ADD,  16'd2477);   // between 13 and 14, not a channel
      send_word(KIND_TEST, 16'd2482);
      send_word(KIND_TEST, 16'd2417);   // channel 2 never added
      send_word(KIND_ADD,  16'd2413);   // off grid
      send_word(KIND_ADD,  16'd2407);   // base itself, below the band
      send_word(KIND_ADD,  16'd5005);
      send_word(KIND_TEST, 16'd5005);
      send_word(KIND_ADD,  16'd5895);   // top of the 5 GHz range
      send_word(KIND_TEST, 16'd5900);   // just past it
      send_word(KIND_ADD,  16'd4905);   // bottom of the 4.9 GHz range
      send_word(KIND_TEST, 16'd4995);   // channel 199 never added
      send_word(KIND_ADD,  16'd4900);
      send_word(KIND_ADD,  16'd4999);   // off grid
      send_word(KIND_TEST, 16'd5000);   // in neither range
      send_word(KIND_ADD,  16'd0);
      send_word(KIND_TEST, 16'hffff);
      send_word(KIND_ADD,  16'd2412);   // repeated add still hits
      send_word(KIND_TEST, 16'd5006);
   endtask

   // random words, idle pattern reshuffled every so often
   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            pop_quiet  = ($urandom_range(0, 3) == 0);
         end
         send_word(kind_type'($urandom_range(0, 1)), pick_freq());
      end
   endtask

   // full rate in both directions
   task automatic test_back_to_back(input int count);
      send_quiet = 1'b1;
      pop_quiet  = 1'b1;
      for (int i = 0; i < count; i++)
         send_word(kind_type'($urandom_range(0, 1)), pick_freq());
      send_quiet = 1'b0;
      pop_quiet  = 1'b0;
   endtask

   // short bursts, each followed by letting the pipeline run dry
   task automatic test_drained_bursts(input int bursts);
      for (int b = 0; b < bursts; b++) begin
         for (int i = 0; i < 20; i++)
            send_word(kind_type'($urandom_range(0, 1)), pick_freq());
         wait_for_drain();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_kind   = 1'b0;
      req_freq   = '0;
      low_set    = '0;
      high_set   = '0;
      errors     = 0;
      cycles     = 0;
      send_quiet = 1'b0;
      pop_quiet  = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(700);
      test_drained_bursts(5);
      test_back_to_back(300);
      test_random_mix(500);

      // all words in, let the owed responses come back
      wait_for_drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
